@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PRRR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PRRR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/prrr_pkg.sv @@
// Types and constants of the periodic report round-robin scheduler.
package prrr_pkg;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_RAISE = 3'd1;
	localparam logic [2:0] REQ_PICK  = 3'd2;
	localparam logic [2:0] REQ_LOAD  = 3'd3;
	localparam logic [2:0] REQ_SETUP = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [5:0]  entry_index;
		logic [15:0] period;
		logic        enable;
		logic [15:0] counter_value;
	} prrr_req_t;

	typedef struct packed {
		logic       picked_valid;
		logic [5:0] picked_index;
		logic [6:0] pending_count;
	} prrr_rsp_t;

	// One report entry as it travels around the ring.
	typedef struct packed {
		logic        flag;
		logic        enable;
		logic [15:0] period;
		logic [15:0] counter;
	} prrr_entry_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_TICK  = 3'd1,
		OP_RAISE = 3'd2,
		OP_LOAD  = 3'd3,
		OP_SETUP = 3'd4,
		OP_CLEAR = 3'd5
	} prrr_op_t;

	// Control handed to the head unit for the entry passing through it.
	typedef struct packed {
		prrr_op_t    op;
		logic        hit;
		logic [15:0] period;
		logic        enable;
		logic [15:0] counter_value;
	} prrr_ctrl_t;

endpackage

@@ rtl/prrr_cell.sv @@
// One ring cell: holds a single report entry and takes its neighbor's entry on a shift.
module prrr_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  prrr_pkg::prrr_entry_t d,
	output prrr_pkg::prrr_entry_t q
);

	prrr_pkg::prrr_entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

@@ rtl/prrr_head.sv @@
// Head unit: applies the current request to the entry leaving the front of the ring.
module prrr_head (
	input  prrr_pkg::prrr_ctrl_t  ctrl,
	input  prrr_pkg::prrr_entry_t ent_in,
	output prrr_pkg::prrr_entry_t ent_out
);

	logic [15:0] next_count;

	assign next_count = ent_in.counter + 16'd1;

	always_comb begin
		ent_out = ent_in;
		case (ctrl.op)
			prrr_pkg::OP_TICK: begin
				if (ent_in.enable) begin
					if (next_count > ent_in.period) begin
						ent_out.counter = '0;
						ent_out.flag    = 1'b1;
					end else begin
						ent_out.counter = next_count;
					end
				end
			end
			prrr_pkg::OP_RAISE: begin
				if (ctrl.hit) ent_out.flag = 1'b1;
			end
			prrr_pkg::OP_LOAD: begin
				if (ctrl.hit) ent_out.counter = ctrl.counter_value;
			end
			prrr_pkg::OP_SETUP: begin
				if (ctrl.hit) begin
					ent_out.enable = ctrl.enable;
					ent_out.period = ctrl.period;
				end
			end
			prrr_pkg::OP_CLEAR: begin
				if (ctrl.hit) ent_out.flag = 1'b0;
			end
			default: begin
				ent_out = ent_in;
			end
		endcase
	end

endmodule

@@ rtl/periodic_report_round_robin_scheduler.sv @@
// Top level of the periodic report round-robin scheduler.
//
// Usage: present a request on req and raise start while busy is low; the
// transfer happens at that clock edge and busy rises in the next cycle.
// Request types are tick, raise flag, pick next, load counter and setup
// entry. Every request yields exactly one result on rsp, marked by done for
// a single cycle; the receiver cannot hold it off, so it must take it then.
//
// The entries live in a ring of ENTRIES cells. While a request is worked on
// the ring rotates by one cell per cycle and the entry leaving the front
// passes through the head unit, which applies the request to it before it
// re-enters at the back. One full rotation brings every entry back home.
//
// Sequence: a pick needs two rotations, a search rotation that finds the
// next pending entry after the last one served and an update rotation that
// clears its flag and counts pending flags, and done follows the update
// rotation. All other requests need only the update rotation before done.
// busy falls the cycle after done.
//
// Reset (arst_n low) clears all entries, the last-served pointer and the
// controller; the block is ready as soon as reset is released.
module periodic_report_round_robin_scheduler #(
	parameter int ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  prrr_pkg::prrr_req_t req,
	output logic                busy,
	output logic                done,
	output prrr_pkg::prrr_rsp_t rsp
);

	localparam int KW   = $clog2(ENTRIES);
	localparam int XW   = (KW > 6) ? KW : 6;
	localparam int CNTW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_PASS = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t              state_q;
	prrr_pkg::prrr_req_t req_q;
	prrr_pkg::prrr_op_t  op_q;
	logic                pick_q;
	logic [KW-1:0]       k_q;
	logic [KW-1:0]       last_q;
	logic [CNTW-1:0]     cnt_q;

	// Search results: first pending entry after the last served one (hi) and
	// first pending entry at or before it (lo), which wraps around.
	logic                hi_found_q;
	logic [KW-1:0]       hi_idx_q;
	logic                lo_found_q;
	logic [KW-1:0]       lo_idx_q;

	logic                win_valid;
	logic [KW-1:0]       win_idx;
	logic                accept;
	logic                shift;
	logic                last_step;

	prrr_pkg::prrr_entry_t ring [ENTRIES];
	prrr_pkg::prrr_entry_t head_out;
	prrr_pkg::prrr_ctrl_t  ctrl;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign shift     = (state_q == ST_SCAN) || (state_q == ST_PASS);
	assign last_step = (k_q == KW'(ENTRIES - 1));
	assign win_valid = hi_found_q || lo_found_q;
	assign win_idx   = hi_found_q ? hi_idx_q : lo_idx_q;

	// The ring: each cell takes its upper neighbor; the back takes the head's output.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_back
			prrr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (head_out),
				.q      (ring[i])
			);
		end else begin : g_mid
			prrr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (ring[i+1]),
				.q      (ring[i])
			);
		end
	end

	// The search rotation leaves entries untouched; the update rotation applies the request.
	always_comb begin
		ctrl.op            = (state_q == ST_PASS) ? op_q : prrr_pkg::OP_NONE;
		ctrl.period        = req_q.period;
		ctrl.enable        = req_q.enable;
		ctrl.counter_value = req_q.counter_value;
		if (pick_q) begin
			ctrl.hit = win_valid && (k_q == win_idx);
		end else begin
			ctrl.hit = (XW'(k_q) == XW'(req_q.entry_index));
		end
	end

	prrr_head u_head (
		.ctrl    (ctrl),
		.ent_in  (ring[0]),
		.ent_out (head_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= prrr_pkg::OP_NONE;
			pick_q     <= 1'b0;
			k_q        <= '0;
			last_q     <= '0;
			cnt_q      <= '0;
			hi_found_q <= 1'b0;
			hi_idx_q   <= '0;
			lo_found_q <= 1'b0;
			lo_idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q        <= '0;
						cnt_q      <= '0;
						hi_found_q <= 1'b0;
						lo_found_q <= 1'b0;
						pick_q     <= (req.req_type == prrr_pkg::REQ_PICK);
						state_q    <= (req.req_type == prrr_pkg::REQ_PICK) ? ST_SCAN : ST_PASS;
						case (req.req_type)
							prrr_pkg::REQ_TICK:  op_q <= prrr_pkg::OP_TICK;
							prrr_pkg::REQ_RAISE: op_q <= prrr_pkg::OP_RAISE;
							prrr_pkg::REQ_PICK:  op_q <= prrr_pkg::OP_CLEAR;
							prrr_pkg::REQ_LOAD:  op_q <= prrr_pkg::OP_LOAD;
							prrr_pkg::REQ_SETUP: op_q <= prrr_pkg::OP_SETUP;
							default:             op_q <= prrr_pkg::OP_NONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (ring[0].flag) begin
						if ((k_q > last_q) && !hi_found_q) begin
							hi_found_q <= 1'b1;
							hi_idx_q   <= k_q;
						end
						if ((k_q <= last_q) && !lo_found_q) begin
							lo_found_q <= 1'b1;
							lo_idx_q   <= k_q;
						end
					end
					if (last_step) begin
						k_q     <= '0;
						state_q <= ST_PASS;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_PASS: begin
					cnt_q <= cnt_q + CNTW'(head_out.flag);
					if (last_step) begin
						k_q     <= '0;
						state_q <= ST_DONE;
						if (pick_q && win_valid) last_q <= win_idx;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload is captured on the transfer and needs no reset.
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
	end

	assign done              = (state_q == ST_DONE);
	assign rsp.picked_valid  = pick_q && win_valid;
	assign rsp.picked_index  = (pick_q && win_valid) ? 6'(win_idx) : 6'd0;
	assign rsp.pending_count = (9'(cnt_q) > 9'd127) ? 7'd127 : 7'(cnt_q);

`include "assert_macros.svh"

	`PRRR_ASSERT_NXT(a_accept_busy, accept, busy, "busy did not rise after a transfer")
	`PRRR_ASSERT_NXT(a_done_idle, done, !busy && !done, "block not idle after a result")
	`PRRR_ASSERT_IMP(a_done_aligned, done, k_q == '0, "ring not back home at a result")
	`PRRR_ASSERT_IMP(a_pick_pending, done && rsp.picked_valid, 9'(cnt_q) < 9'(ENTRIES),
		"pick reported with every flag still pending")

endmodule

@@ verif/periodic_report_round_robin_scheduler_tb.sv @@
// Self-checking testbench for the periodic report round-robin scheduler.
`timescale 1ns / 1ps

module periodic_report_round_robin_scheduler_tb;

	localparam int N_ENTRIES = 64;

	// Request codes that the block has no use for; they must leave the table alone.
	localparam logic [2:0] REQ_RSVD5 = 3'd5;
	localparam logic [2:0] REQ_RSVD6 = 3'd6;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	// A pick takes two rotations of the ring, which is the longest time a
	// result can take. The drain wait at the end allows that and a margin.
	localparam int PICK_LATENCY = 2 * N_ENTRIES + 1;

	localparam int RANDOM_ITEMS = 1000;

	// One row of the directed part. Where has_lit is set the expected result is
	// written into the row; otherwise the scheduler model supplies it.
	typedef struct {
		prrr_pkg::prrr_req_t r;
		bit                  has_lit;
		prrr_pkg::prrr_rsp_t lit;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	prrr_pkg::prrr_req_t req = '0;
	logic                busy;
	logic                done;
	prrr_pkg::prrr_rsp_t rsp;

	// Model copy of the report table and of the round-robin pointer.
	logic        pend_flag [N_ENTRIES];
	logic [15:0] tick_cnt [N_ENTRIES];
	logic [15:0] entry_period [N_ENTRIES];
	logic        entry_en [N_ENTRIES];
	int unsigned last_pick;

	// Results still owed by the block, oldest first.
	prrr_pkg::prrr_rsp_t reports_due [$];
	prrr_pkg::prrr_rsp_t oldest_report;
	int unsigned         xfer_count = 0;
	int unsigned         mismatches = 0;

	dir_row_t    dir_rows [$];
	bit          idle_on;

	periodic_report_round_robin_scheduler #(
		.ENTRIES(N_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the model table and returns the report that the
	// block has to produce for it.
	function automatic prrr_pkg::prrr_rsp_t next_report(prrr_pkg::prrr_req_t r);
		prrr_pkg::prrr_rsp_t o;
		logic [15:0]         c;
		int unsigned         e;
		int unsigned         n;
		bit                  found;
		o = '0;
		found = 1'b0;
		case (r.req_type)
			prrr_pkg::REQ_TICK: begin
				for (int i = 0; i < N_ENTRIES; i++) begin
					if (entry_en[i]) begin
						c = tick_cnt[i] + 16'd1;
						// A counter that wraps to zero never exceeds its period.
						if (c > entry_period[i]) begin
							c = '0;
							pend_flag[i] = 1'b1;
						end
						tick_cnt[i] = c;
					end
				end
			end
			prrr_pkg::REQ_RAISE: begin
				// The flag is set even when the entry is disabled.
				if (r.entry_index < N_ENTRIES)
					pend_flag[r.entry_index] = 1'b1;
			end
			prrr_pkg::REQ_PICK: begin
				// Search starts just after the last entry served and looks at that
				// entry itself last. With nothing pending the pointer stays put.
				e = last_pick;
				for (int s = 0; s < N_ENTRIES; s++) begin
					e = (e + 1) % N_ENTRIES;
					if (!found && pend_flag[e]) begin
						found = 1'b1;
						pend_flag[e] = 1'b0;
						last_pick = e;
						o.picked_valid = 1'b1;
						o.picked_index = 6'(e);
					end
				end
			end
			prrr_pkg::REQ_LOAD: begin
				if (r.entry_index < N_ENTRIES)
					tick_cnt[r.entry_index] = r.counter_value;
			end
			prrr_pkg::REQ_SETUP: begin
				// Setup keeps the counter and the flag of the entry.
				if (r.entry_index < N_ENTRIES) begin
					entry_en[r.entry_index] = r.enable;
					entry_period[r.entry_index] = r.period;
				end
			end
			default: begin
			end
		endcase
		n = 0;
		for (int i = 0; i < N_ENTRIES; i++)
			n += pend_flag[i] ? 1 : 0;
		o.pending_count = (n > 127) ? 7'd127 : 7'(n);
		return o;
	endfunction

	// Random request. Most setups enable the entry with a short period and most
	// loads preset a small count, so that ticks actually raise flags and picks
	// have something to find. The other fields are random on every request.
	function automatic prrr_pkg::prrr_req_t random_request();
		prrr_pkg::prrr_req_t r;
		int unsigned         roll;
		r.req_type = prrr_pkg::REQ_TICK;
		r.entry_index = 6'($urandom);
		r.period = 16'($urandom);
		r.enable = 1'($urandom);
		r.counter_value = 16'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			r.req_type = prrr_pkg::REQ_TICK;
		end else if (roll < 55) begin
			r.req_type = prrr_pkg::REQ_PICK;
		end else if (roll < 67) begin
			r.req_type = prrr_pkg::REQ_RAISE;
		end else if (roll < 82) begin
			r.req_type = prrr_pkg::REQ_SETUP;
			if ($urandom_range(0, 3) != 0)
				r.enable = 1'b1;
			if ($urandom_range(0, 4) != 0)
				r.period = 16'($urandom_range(0, 7));
		end else if (roll < 94) begin
			r.req_type = prrr_pkg::REQ_LOAD;
			if ($urandom_range(0, 4) != 0)
				r.counter_value = 16'($urandom_range(0, 8));
		end else begin
			// Any code at all, the unused ones included.
			r.req_type = 3'($urandom);
		end
		return r;
	endfunction

	task automatic add_row(input logic [2:0] kind, input logic [5:0] idx,
			input logic [15:0] per, input logic en, input logic [15:0] cv,
			input bit has_lit, input logic pv, input logic [5:0] pidx,
			input logic [6:0] cnt);
		dir_row_t row;
		row.r = '{req_type: kind, entry_index: idx, period: per, enable: en,
			counter_value: cv};
		row.has_lit = has_lit;
		row.lit = '{picked_valid: pv, picked_index: pidx, pending_count: cnt};
		dir_rows.push_back(row);
	endtask

	// Offers one request to the block and returns, at a falling edge, once the
	// transfer has taken place. The caller is at a falling edge. With drain set
	// the sender first holds back until every owed result has come.
	task automatic send_request(input prrr_pkg::prrr_req_t r, input bit has_lit,
			input prrr_pkg::prrr_rsp_t lit, input bit drain);
		int unsigned         gap;
		int unsigned         seen;
		prrr_pkg::prrr_rsp_t want;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (drain || gap != 0)
			start <= 1'b0;
		if (drain) begin
			while (reports_due.size() != 0)
				@(negedge clk);
		end
		repeat (gap) @(negedge clk);
		start <= 1'b1;
		req <= r;
		seen = xfer_count;
		do
			@(negedge clk);
		while (xfer_count == seen);
		want = next_report(r);
		if (has_lit)
			want = lit;
		reports_due.push_back(want);
	endtask

	// Everything on the block side is sampled at the rising edge. A transfer is
	// counted for the sender, and each result is checked against the oldest
	// owed one, field by field.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				xfer_count++;
			if (done) begin
				if (reports_due.size() == 0) begin
					$error("result arrived with none owed: valid %0d index %0d count %0d",
						rsp.picked_valid, rsp.picked_index, rsp.pending_count);
					mismatches++;
				end else begin
					oldest_report = reports_due.pop_front();
					if (rsp.picked_valid !== oldest_report.picked_valid) begin
						$error("picked_valid: expected %0d, got %0d",
							oldest_report.picked_valid, rsp.picked_valid);
						mismatches++;
					end
					if (rsp.picked_index !== oldest_report.picked_index) begin
						$error("picked_index: expected %0d, got %0d",
							oldest_report.picked_index, rsp.picked_index);
						mismatches++;
					end
					if (rsp.pending_count !== oldest_report.pending_count) begin
						$error("pending_count: expected %0d, got %0d",
							oldest_report.pending_count, rsp.pending_count);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < N_ENTRIES; i++) begin
			pend_flag[i] = 1'b0;
			tick_cnt[i] = '0;
			entry_period[i] = '0;
			entry_en[i] = 1'b0;
		end
		last_pick = 0;
		idle_on = 1'b1;

		// Directed part. The walk starts with a pick on the empty table, serves
		// the two end entries in ring order, and then covers a zero period, a
		// counter that wraps at the largest period, the unused codes with every
		// field set, a raise on a disabled entry, setup keeping the counter, and
		// a final pick with nothing pending that must leave the pointer alone.
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_RAISE, 6'd63, 16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd1);
		add_row(prrr_pkg::REQ_RAISE, 6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd2);
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b1, 6'd63, 7'd1);
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b1, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_SETUP, 6'd5,  16'h0000, 1'b1, 16'h0000, 1, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_TICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd1);
		add_row(prrr_pkg::REQ_SETUP, 6'd7,  16'hFFFF, 1'b1, 16'h0000, 1, 1'b0, 6'd0,  7'd1);
		add_row(prrr_pkg::REQ_LOAD,  6'd7,  16'h0000, 1'b0, 16'hFFFF, 1, 1'b0, 6'd0,  7'd1);
		add_row(prrr_pkg::REQ_TICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 0, 1'b0, 6'd0,  7'd0);
		add_row(REQ_RSVD5,           6'd63, 16'hFFFF, 1'b1, 16'hFFFF, 1, 1'b0, 6'd0,  7'd1);
		add_row(REQ_RSVD6,           6'd63, 16'hFFFF, 1'b1, 16'hFFFF, 1, 1'b0, 6'd0,  7'd1);
		add_row(REQ_RSVD7,           6'd63, 16'hFFFF, 1'b1, 16'hFFFF, 1, 1'b0, 6'd0,  7'd1);
		add_row(prrr_pkg::REQ_RAISE, 6'd20, 16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd2);
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b1, 6'd5,  7'd1);
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b1, 6'd20, 7'd0);
		add_row(prrr_pkg::REQ_SETUP, 6'd5,  16'hFFFF, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_SETUP, 6'd63, 16'h0001, 1'b1, 16'h0000, 1, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_TICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 0, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_TICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 0, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_LOAD,  6'd63, 16'h0000, 1'b0, 16'hFFFF, 1, 1'b0, 6'd0,  7'd1);
		add_row(prrr_pkg::REQ_TICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 0, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b1, 6'd63, 7'd0);
		add_row(prrr_pkg::REQ_PICK,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd0);
		add_row(prrr_pkg::REQ_LOAD,  6'd0,  16'h0000, 1'b0, 16'h0000, 1, 1'b0, 6'd0,  7'd0);

		// Reset once, released at a falling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].r, dir_rows[i].has_lit, dir_rows[i].lit, 1'b0);

		// Random part. The sender gap is switched on and off in stretches, and
		// now and then the sender holds back until the block has caught up, the
		// first such pause right at the start of this part.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 64 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			send_request(random_request(), 1'b0, '0,
				(k == 0) || ($urandom_range(0, 99) == 0));
		end
		start <= 1'b0;

		while (reports_due.size() != 0)
			@(negedge clk);
		// Any result after this point is one too many and is caught by the checker.
		repeat (PICK_LATENCY + 8) @(negedge clk);

		if (mismatches == 0)
			$display("periodic_report_round_robin_scheduler: match");
		else
			$display("periodic_report_round_robin_scheduler: mismatch");
		$finish;
	end

	// The slowest correct run is about 1.5 ms of simulated time.
	initial begin
		#20_000_000;
		$display("periodic_report_round_robin_scheduler: mismatch");
		$finish;
	end

endmodule
